[hw/rtl/svpwm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package svpwm_pkg;

  // sine table size and sample width
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MAG_W = SAMPLE_BITS - 1;
  // alpha and beta stay within plus or minus 65536
  localparam int AB_W = 18;
  localparam int SEC_W = 3;
  // active times after the round shift
  localparam int T_W = 20;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [ADDR_W-1:0] rom_addr_t;
  typedef mag_t sine_rom_t [0:SINE_TABLE_DEPTH];

  typedef struct packed {
    logic [15:0]        rotor_angle;
    logic signed [15:0] volt_d;
    logic signed [15:0] volt_q;
  } svpwm_in_t;

  typedef struct packed {
    logic [15:0]      duty_u;
    logic [15:0]      duty_v;
    logic [15:0]      duty_w;
    logic [SEC_W-1:0] sector_number;
    logic             duty_clipped;
  } svpwm_out_t;

  typedef struct packed {
    mag_t               sin_mag;
    mag_t               cos_mag;
    logic               sin_neg;
    logic               cos_neg;
    logic signed [15:0] volt_d;
    logic signed [15:0] volt_q;
  } trig_t;

  typedef struct packed {
    logic signed [AB_W-1:0] alpha;
    logic signed [AB_W-1:0] beta;
  } ab_t;

  typedef struct packed {
    logic [SEC_W-1:0]      sector;
    logic signed [T_W-1:0] t_m;
    logic signed [T_W-1:0] t_n;
  } times_t;

  // pi/2 in Q30 and the taylor divisors (2n)(2n+1)
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] TaylorDiv [1:5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  // one quarter-wave entry, sin(k*pi/(2*depth)) by a truncated taylor series in Q30
  function automatic mag_t rom_entry(input int unsigned k);
    logic [63:0]        amp;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic signed [63:0] sum;
    amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    x = (HalfPiQ30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int n = 1; n <= 5; n++) begin
      term = (term * x2) >> 30;
      term = term / TaylorDiv[n];
      if (n inside {1, 3, 5}) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    prod = ($unsigned(sum) * amp + 64'd536870912) >> 30;
    if (prod > amp) begin
      prod = amp;
    end
    return mag_t'(prod);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      rom[k] = rom_entry(k);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/svpwm_duty_generator.sv]
// space vector pwm duty generator with inverse park transform. each input beat carries a
// rotor angle (65536 per turn) and q1.15 d/q voltage commands; each output beat carries the
// three phase duties (0..65535), the sector 1..6 and a flag set when any duty had to be
// saturated. one beat is accepted every clock cycle unless the output stalls; each beat passes
// through angle decode and quarter-wave sine rom read (one rom, two read ports, depth+1
// entries, built at elaboration), the four d/q products and their rounded sums, the sqrt3
// product, sector choice and active times, and the phase sums, saturation and final
// scaling. the pipeline moves as a whole: while a result
// waits on out_ready every stage holds and in_ready stays low, so no beat is lost or doubled.
// a zero vector gives sector 4 with all duties at half. no configuration, no reset-time
// initialisation sweep.
`timescale 1ns / 1ps
`default_nettype none

module svpwm_duty_generator (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire svpwm_pkg::svpwm_in_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output svpwm_pkg::svpwm_out_t      out_data
);
  import svpwm_pkg::*;

  // register stages from input beat to output register
  localparam int STAGES = 9;

  logic              adv;
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  trig_t             trig;
  ab_t               ab;
  times_t            times;

  // whole pipe advances when the output register is empty or being taken
  assign adv      = ~vld_r[STAGES-1] | out_ready;
  assign in_ready = adv;
  assign vld_nxt  = {vld_r[STAGES-2:0], in_valid};

  // valid bits travel alongside the data stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[STAGES-1];

  // angle decode and sine/cosine lookup
  svpwm_sincos u_sincos (
    .clk     (clk),
    .adv     (adv),
    .in_data (in_data),
    .trig    (trig)
  );

  // d/q rotated into alpha/beta
  svpwm_park u_park (
    .clk  (clk),
    .adv  (adv),
    .trig (trig),
    .ab   (ab)
  );

  // sector and the two active times
  svpwm_sector u_sector (
    .clk   (clk),
    .adv   (adv),
    .ab    (ab),
    .times (times)
  );

  // phase duties, saturation and output register
  svpwm_duty u_duty (
    .clk      (clk),
    .adv      (adv),
    .times    (times),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

[hw/rtl/svpwm_sincos.sv]
`timescale 1ns / 1ps
`default_nettype none

module svpwm_sincos (
  input  wire logic                  clk,
  input  wire logic                  adv,
  input  wire svpwm_pkg::svpwm_in_t  in_data,
  output svpwm_pkg::trig_t           trig
);
  import svpwm_pkg::*;

  localparam int IDXP_W = 14 + ADDR_W;
  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [IDXP_W-1:0] idx_prod;
  rom_addr_t         idx;
  rom_addr_t         idx_flip;
  logic [1:0]        quad_s;
  logic [1:0]        quad_c;
  rom_addr_t         sin_addr_nxt;
  rom_addr_t         cos_addr_nxt;

  // address stage
  rom_addr_t          sin_addr_r;
  rom_addr_t          cos_addr_r;
  logic               sin_neg_r;
  logic               cos_neg_r;
  logic signed [15:0] volt_d_r;
  logic signed [15:0] volt_q_r;

  // rom read stage
  mag_t               sin_mag_r;
  mag_t               cos_mag_r;
  logic               sin_neg_r2;
  logic               cos_neg_r2;
  logic signed [15:0] volt_d_r2;
  logic signed [15:0] volt_q_r2;

  // cosine is the sine a quarter turn on: same index, next quadrant
  assign idx_prod = IDXP_W'(in_data.rotor_angle[13:0]) * IDXP_W'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[IDXP_W-1:14];
  assign idx_flip = rom_addr_t'(SINE_TABLE_DEPTH) - idx;
  assign quad_s   = in_data.rotor_angle[15:14];
  assign quad_c   = quad_s + 2'd1;

  always_comb begin
    sin_addr_nxt = quad_s[0] ? idx_flip : idx;
    cos_addr_nxt = quad_c[0] ? idx_flip : idx;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_addr_r <= sin_addr_nxt;
      cos_addr_r <= cos_addr_nxt;
      sin_neg_r  <= quad_s[1];
      cos_neg_r  <= quad_c[1];
      volt_d_r   <= in_data.volt_d;
      volt_q_r   <= in_data.volt_q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_mag_r  <= SINE_ROM[sin_addr_r];
      cos_mag_r  <= SINE_ROM[cos_addr_r];
      sin_neg_r2 <= sin_neg_r;
      cos_neg_r2 <= cos_neg_r;
      volt_d_r2  <= volt_d_r;
      volt_q_r2  <= volt_q_r;
    end
  end

  always_comb begin
    trig.sin_mag = sin_mag_r;
    trig.cos_mag = cos_mag_r;
    trig.sin_neg = sin_neg_r2;
    trig.cos_neg = cos_neg_r2;
    trig.volt_d  = volt_d_r2;
    trig.volt_q  = volt_q_r2;
  end

endmodule

`default_nettype wire

[hw/rtl/svpwm_park.sv]
`timescale 1ns / 1ps
`default_nettype none

module svpwm_park (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire svpwm_pkg::trig_t  trig,
  output svpwm_pkg::ab_t         ab
);
  import svpwm_pkg::*;

  localparam int PR_W = 16 + SAMPLE_BITS;
  localparam int SUM_W = PR_W + 1;
  localparam logic signed [SUM_W-1:0] RoundHalf = SUM_W'(2 ** (SAMPLE_BITS - 2));

  logic signed [SAMPLE_BITS-1:0] sin_s;
  logic signed [SAMPLE_BITS-1:0] cos_s;
  logic signed [SUM_W-1:0]       a_sum;
  logic signed [SUM_W-1:0]       b_sum;
  logic signed [AB_W-1:0]        alpha_nxt;
  logic signed [AB_W-1:0]        beta_nxt;

  logic signed [PR_W-1:0] dc_r;
  logic signed [PR_W-1:0] qs_r;
  logic signed [PR_W-1:0] ds_r;
  logic signed [PR_W-1:0] qc_r;
  logic signed [AB_W-1:0] alpha_r;
  logic signed [AB_W-1:0] beta_r;

  assign sin_s = trig.sin_neg ? -$signed({1'b0, trig.sin_mag}) : $signed({1'b0, trig.sin_mag});
  assign cos_s = trig.cos_neg ? -$signed({1'b0, trig.cos_mag}) : $signed({1'b0, trig.cos_mag});

  // product stage
  always_ff @(posedge clk) begin
    if (adv) begin
      dc_r <= PR_W'(trig.volt_d) * PR_W'(cos_s);
      qs_r <= PR_W'(trig.volt_q) * PR_W'(sin_s);
      ds_r <= PR_W'(trig.volt_d) * PR_W'(sin_s);
      qc_r <= PR_W'(trig.volt_q) * PR_W'(cos_s);
    end
  end

  // inverse park, rounded half up
  always_comb begin
    a_sum     = SUM_W'(dc_r) - SUM_W'(qs_r) + RoundHalf;
    b_sum     = SUM_W'(ds_r) + SUM_W'(qc_r) + RoundHalf;
    alpha_nxt = AB_W'(a_sum >>> (SAMPLE_BITS - 1));
    beta_nxt  = AB_W'(b_sum >>> (SAMPLE_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      alpha_r <= alpha_nxt;
      beta_r  <= beta_nxt;
    end
  end

  always_comb begin
    ab.alpha = alpha_r;
    ab.beta  = beta_r;
  end

endmodule

`default_nettype wire

[hw/rtl/svpwm_sector.sv]
`timescale 1ns / 1ps
`default_nettype none

module svpwm_sector (
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire svpwm_pkg::ab_t  ab,
  output svpwm_pkg::times_t    times
);
  import svpwm_pkg::*;

  localparam int P_W = AB_W + 31;
  localparam int S_W = P_W + 2;
  localparam logic [31:0] Sqrt3Q30 = 32'd1859775393;
  localparam logic signed [S_W-1:0] RoundQ31 = S_W'(64'd1073741824);

  localparam logic [SEC_W-1:0] SectorOfK [0:7] = '{3'd4, 3'd6, 3'd5, 3'd5, 3'd3, 3'd1, 3'd2, 3'd2};
  // 2*sin and 2*cos of multiples of 60 degrees, in units of sqrt3 and of one
  localparam logic signed [1:0] SinSign [0:7] =
    '{2'sd0, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, 2'sd0, 2'sd0};
  localparam logic signed [2:0] CosMul [0:7] =
    '{3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd1, 3'sd1, 3'sd2, 3'sd0};

  function automatic logic signed [S_W-1:0] sin_term(input logic [SEC_W-1:0] s,
                                                      input logic signed [P_W-1:0] p);
    logic signed [S_W-1:0] pe;
    pe = S_W'(p);
    case (SinSign[s])
      2'b01:   return pe;
      2'b11:   return -pe;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [S_W-1:0] cos_term(input logic [SEC_W-1:0] s,
                                                      input logic signed [AB_W-1:0] b);
    logic signed [S_W-1:0] prod;
    prod = S_W'(b) * S_W'(CosMul[s]);
    return prod <<< 30;
  endfunction

  // multiply stage
  logic signed [P_W-1:0]  p_r;
  logic signed [AB_W-1:0] beta_r;

  // sector stage
  logic signed [P_W-1:0]  abs_p;
  logic signed [AB_W-1:0] abs_b;
  logic signed [P_W-1:0]  b_scaled;
  logic                   slope;
  logic [2:0]             k_code;
  logic [SEC_W-1:0]       sec_nxt;
  logic [SEC_W-1:0]       sec_r;
  logic signed [P_W-1:0]  p_r2;
  logic signed [AB_W-1:0] beta_r2;

  // times stage
  logic [SEC_W-1:0]       sec_prev;
  logic signed [S_W-1:0]  tm_sum;
  logic signed [S_W-1:0]  tn_sum;
  logic [SEC_W-1:0]       sec_r3;
  logic signed [T_W-1:0]  tm_r;
  logic signed [T_W-1:0]  tn_r;

  // p = sqrt3 * alpha, shared by the slope test and both active times
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r    <= P_W'(ab.alpha) * P_W'($signed(Sqrt3Q30));
      beta_r <= ab.beta;
    end
  end

  // sign of alpha follows p
  always_comb begin
    abs_p    = p_r[P_W-1] ? -p_r : p_r;
    abs_b    = beta_r[AB_W-1] ? -beta_r : beta_r;
    b_scaled = P_W'(abs_b) <<< 30;
    slope    = b_scaled > abs_p;
    k_code   = {beta_r > 0, slope, p_r > 0};
    sec_nxt  = SectorOfK[k_code];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sec_r   <= sec_nxt;
      p_r2    <= p_r;
      beta_r2 <= beta_r;
    end
  end

  always_comb begin
    sec_prev = sec_r - 3'd1;
    tm_sum   = sin_term(sec_r, p_r2) - cos_term(sec_r, beta_r2) + RoundQ31;
    tn_sum   = cos_term(sec_prev, beta_r2) - sin_term(sec_prev, p_r2) + RoundQ31;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sec_r3 <= sec_r;
      tm_r   <= T_W'(tm_sum >>> 31);
      tn_r   <= T_W'(tn_sum >>> 31);
    end
  end

  always_comb begin
    times.sector = sec_r3;
    times.t_m    = tm_r;
    times.t_n    = tn_r;
  end

endmodule

`default_nettype wire

[hw/rtl/svpwm_duty.sv]
`timescale 1ns / 1ps
`default_nettype none

module svpwm_duty (
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire svpwm_pkg::times_t  times,
  output svpwm_pkg::svpwm_out_t   out_data
);
  import svpwm_pkg::*;

  localparam int F_W = T_W + 4;
  localparam int FS_W = 17;
  localparam int SC_W = 34;

  // switching vectors applied for t_m (VecCur) and t_n (VecNxt) in each sector, bit n is phase n
  localparam logic [2:0] VecCur [0:7] =
    '{3'b000, 3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b101, 3'b000};
  localparam logic [2:0] VecNxt [0:7] =
    '{3'b000, 3'b011, 3'b010, 3'b110, 3'b100, 3'b101, 3'b001, 3'b000};

  logic signed [F_W-1:0] tm2;
  logic signed [F_W-1:0] tn2;
  logic signed [F_W-1:0] t0;
  logic signed [F_W-1:0] f_val [0:2];
  logic [FS_W-1:0]       fsat_nxt [0:2];
  logic                  clip_nxt;
  logic [SC_W-1:0]       scaled [0:2];

  logic [FS_W-1:0]  fsat_r [0:2];
  logic             clip_r;
  logic [SEC_W-1:0] sec_r;
  svpwm_out_t       out_r;

  always_comb begin
    tm2      = F_W'(times.t_m) <<< 1;
    tn2      = F_W'(times.t_n) <<< 1;
    t0       = F_W'(32768) - F_W'(times.t_m) - F_W'(times.t_n);
    clip_nxt = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      f_val[ph] = t0 + (VecCur[times.sector][ph] ? tm2 : '0)
                     + (VecNxt[times.sector][ph] ? tn2 : '0);
      if (f_val[ph] < 0) begin
        fsat_nxt[ph] = '0;
        clip_nxt     = 1'b1;
      end else if (f_val[ph] > F_W'(65536)) begin
        fsat_nxt[ph] = FS_W'(65536);
        clip_nxt     = 1'b1;
      end else begin
        fsat_nxt[ph] = FS_W'(f_val[ph]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fsat_r <= fsat_nxt;
      clip_r <= clip_nxt;
      sec_r  <= times.sector;
    end
  end

  // duty = (f * 65535 + half) >> 16, with the multiply as a shift and subtract
  always_comb begin
    for (int ph = 0; ph < 3; ph++) begin
      scaled[ph] = (SC_W'(fsat_r[ph]) << 16) - SC_W'(fsat_r[ph]) + SC_W'(32768);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.duty_u        <= scaled[0][31:16];
      out_r.duty_v        <= scaled[1][31:16];
      out_r.duty_w        <= scaled[2][31:16];
      out_r.sector_number <= sec_r;
      out_r.duty_clipped  <= clip_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[hw/rtl/svpwm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module svpwm_checker (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire svpwm_pkg::svpwm_in_t   in_data,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire svpwm_pkg::svpwm_out_t  out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // sector is always one of the six
  a_sector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sector_number >= 3'd1 && out_data.sector_number <= 3'd6))
    else $error("sector out of range");

  // clip flag only with a saturated duty
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.duty_clipped |->
      (out_data.duty_u == 16'd0 || out_data.duty_u == 16'hFFFF ||
       out_data.duty_v == 16'd0 || out_data.duty_v == 16'hFFFF ||
       out_data.duty_w == 16'd0 || out_data.duty_w == 16'hFFFF))
    else $error("clip flag without a saturated duty");

  // input side never waits on an empty or draining output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with output free");

  // nothing comes out straight after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind svpwm_duty_generator svpwm_checker u_svpwm_checker (.*);

`default_nettype wire

[sim/tb_svpwm_duty_generator.sv]
`timescale 1ns / 1ps

module tb_svpwm_duty_generator;
  import svpwm_pkg::*;

  // fixed-point constants of the duty maths
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint OneQ30 = 64'sd1073741824;
  localparam longint Sqrt3Q30 = 64'sd1859775393;
  // sector per {beta > 0, steep, alpha > 0} code
  localparam int SectorOfCode [8] = '{4, 6, 5, 5, 3, 1, 2, 2};
  // switching vectors, bit 2 is phase u, bit 0 is phase w
  localparam bit [2:0] PhaseOn [6] = '{3'b100, 3'b110, 3'b010, 3'b011, 3'b001, 3'b101};
  // 2*sin and 2*cos of k*60 degrees in q30
  localparam longint Sin2Q30 [7] = '{0, Sqrt3Q30, Sqrt3Q30, 0, -Sqrt3Q30, -Sqrt3Q30, 0};
  localparam longint Cos2Q30 [7] = '{2 * OneQ30, OneQ30, -OneQ30, -2 * OneQ30,
                                     -OneQ30, OneQ30, 2 * OneQ30};
  // a zero vector leaves every phase at half, sector 4
  localparam svpwm_out_t HalfDuties = '{16'd32768, 16'd32768, 16'd32768, 3'd4, 1'b0};

  localparam int BeatsPerPhase = 400;
  localparam int DrainCycles = 30;
  localparam int CycleLimit = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  svpwm_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  svpwm_out_t out_data;

  typedef struct {
    svpwm_in_t  beat;
    bit         typed;
    svpwm_out_t want;
  } probe_t;

  // quarter-wave sine magnitudes, filled before the first beat
  longint     quarter_sine [0:SINE_TABLE_DEPTH];
  // duties still owed by the block, oldest first
  svpwm_out_t duty_book [$];
  probe_t     probes [$];
  int         errors = 0;
  int         cycles = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;

  svpwm_duty_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sin(k*pi/(2*depth)) as a truncated six-term series in q30, scaled to the rom amplitude
  function automatic longint taylor_sine(input int k);
    longint unsigned amp;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    x = (HalfPiQ30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 5; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * longint'(amp) + (OneQ30 >>> 1)) >>> 30;
    if (v > longint'(amp)) begin
      v = longint'(amp);
    end
    return v;
  endfunction

  // table read with quadrant folding, no interpolation
  function automatic longint wave_at(input logic [15:0] ang);
    longint idx;
    longint mag;
    idx = (longint'(ang[13:0]) * SINE_TABLE_DEPTH) >>> 14;
    mag = ang[14] ? quarter_sine[SINE_TABLE_DEPTH - idx] : quarter_sine[idx];
    return ang[15] ? -mag : mag;
  endfunction

  // arithmetic shift right with round half up
  function automatic longint round_shr(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // inverse park, sector choice, active times and the three phase duties
  function automatic svpwm_out_t predict_duties(input svpwm_in_t beat);
    svpwm_out_t   res;
    longint       d;
    longint       q;
    longint       s;
    longint       c;
    longint       alpha;
    longint       beta;
    longint       aa;
    longint       ab;
    longint       tm;
    longint       tn;
    longint       t0;
    longint       f;
    logic [2:0]   code;
    int           sec;
    bit           clip;
    logic [15:0]  duty [3];
    d = longint'(beat.volt_d);
    q = longint'(beat.volt_q);
    s = wave_at(beat.rotor_angle);
    c = wave_at(beat.rotor_angle + 16'd16384);
    alpha = round_shr(d * c - q * s, SAMPLE_BITS - 1);
    beta = round_shr(d * s + q * c, SAMPLE_BITS - 1);
    aa = alpha < 0 ? -alpha : alpha;
    ab = beta < 0 ? -beta : beta;
    code = {beta > 0, ab * OneQ30 > aa * Sqrt3Q30, alpha > 0};
    sec = SectorOfCode[code];
    tm = round_shr(Sin2Q30[sec] * alpha - Cos2Q30[sec] * beta, 31);
    tn = round_shr(Cos2Q30[sec - 1] * beta - Sin2Q30[sec - 1] * alpha, 31);
    t0 = 32768 - tm - tn;
    clip = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      f = 2 * tm * longint'(PhaseOn[sec - 1][2 - ph])
        + 2 * tn * longint'(PhaseOn[sec % 6][2 - ph]) + t0;
      if (f < 0) begin
        duty[ph] = 16'd0;
        clip = 1'b1;
      end else if (f > 65536) begin
        duty[ph] = 16'hFFFF;
        clip = 1'b1;
      end else begin
        duty[ph] = 16'((f * 65535 + 32768) >>> 16);
      end
    end
    res.duty_u = duty[0];
    res.duty_v = duty[1];
    res.duty_w = duty[2];
    res.sector_number = 3'(sec);
    res.duty_clipped = clip;
    return res;
  endfunction

  // one of the command extremes, or one step inside them
  function automatic logic [15:0] edge_volt();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h8001;
      default: return 16'h7FFE;
    endcase
  endfunction

  // random beat: free content, with weight on sector and quadrant edges,
  // on tiny and extreme commands and on commands with one axis at zero
  function automatic svpwm_in_t random_beat();
    svpwm_in_t b;
    b.rotor_angle = 16'($urandom);
    b.volt_d = 16'($urandom);
    b.volt_q = 16'($urandom);
    case ($urandom_range(0, 9))
      4, 5: b.rotor_angle = 16'($urandom_range(0, 5) * 10923 + $urandom_range(0, 16) - 8);
      6: begin
        b.rotor_angle = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 4) - 2);
        b.volt_d = edge_volt();
      end
      7: begin
        b.volt_d = 16'($urandom_range(0, 64) - 32);
        b.volt_q = 16'($urandom_range(0, 64) - 32);
      end
      8: begin
        b.volt_d = edge_volt();
        b.volt_q = edge_volt();
      end
      9: begin
        if ($urandom_range(0, 1) == 0) begin
          b.volt_d = '0;
        end else begin
          b.volt_q = '0;
        end
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic add_probe(input logic [15:0] ang, input logic [15:0] vd,
                           input logic [15:0] vq, input bit typed);
    probe_t p;
    p.beat.rotor_angle = ang;
    p.beat.volt_d = vd;
    p.beat.volt_q = vq;
    p.typed = typed;
    p.want = HalfDuties;
    probes.push_back(p);
  endtask

  // offer one beat, with a random gap first, and book its duties when it is taken
  task automatic send_beat(input svpwm_in_t beat, input bit typed, input svpwm_out_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do begin
      @(posedge clk);
    end while (!in_ready);
    duty_book.push_back(typed ? want : predict_duties(beat));
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver: stalls at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // every result beat against the oldest booked one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (duty_book.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, out_data);
        errors++;
      end else begin
        check_field("duty_u", duty_book[0].duty_u, out_data.duty_u);
        check_field("duty_v", duty_book[0].duty_v, out_data.duty_v);
        check_field("duty_w", duty_book[0].duty_w, out_data.duty_w);
        check_field("sector_number", duty_book[0].sector_number, out_data.sector_number);
        check_field("duty_clipped", duty_book[0].duty_clipped, out_data.duty_clipped);
        void'(duty_book.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_svpwm_duty_generator: done, errors");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      quarter_sine[k] = taylor_sine(k);
    end

    // zero vector at any angle: half duty everywhere, sector 4
    add_probe(16'h0000, 16'h0000, 16'h0000, 1'b1);
    add_probe(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
    add_probe(16'h8000, 16'h0000, 16'h0000, 1'b1);
    add_probe(16'h5555, 16'h0000, 16'h0000, 1'b1);
    // command extremes on each axis, full scale of plus or minus one
    add_probe(16'h0000, 16'h7FFF, 16'h0000, 1'b0);
    add_probe(16'h0000, 16'h8000, 16'h0000, 1'b0);
    add_probe(16'h0000, 16'h0000, 16'h7FFF, 1'b0);
    add_probe(16'h0000, 16'h0000, 16'h8000, 1'b0);
    add_probe(16'h4000, 16'h7FFF, 16'h7FFF, 1'b0);
    add_probe(16'h8000, 16'h8000, 16'h8000, 1'b0);
    add_probe(16'hC000, 16'h7FFF, 16'h8000, 1'b0);
    add_probe(16'hFFFF, 16'h8000, 16'h7FFF, 1'b0);
    add_probe(16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b0);
    // quadrant edges
    add_probe(16'h3FFF, 16'h7FFF, 16'h0000, 1'b0);
    add_probe(16'h4001, 16'h4000, 16'h0000, 1'b0);
    add_probe(16'hBFFF, 16'h4000, 16'hC000, 1'b0);
    // sector edges at multiples of 60 degrees
    add_probe(16'd10923, 16'h0000, 16'h7FFF, 1'b0);
    add_probe(16'd21845, 16'h4000, 16'h0000, 1'b0);
    add_probe(16'd43690, 16'h4000, 16'h0000, 1'b0);
    add_probe(16'd54613, 16'h2000, 16'h2000, 1'b0);
    // one lsb commands
    add_probe(16'h1234, 16'h0001, 16'hFFFF, 1'b0);
    add_probe(16'h0001, 16'hFFFF, 16'hFFFF, 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats, no idling
    foreach (probes[i]) begin
      send_beat(probes[i].beat, probes[i].typed, probes[i].want);
    end

    // random phases: free flow, sender gaps, receiver stalls, both light
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
        default: begin src_idle_pct = 6; sink_stall_pct = 6; end
      endcase
      for (int i = 0; i < BeatsPerPhase; i++) begin
        send_beat(random_beat(), 1'b0, HalfDuties);
      end
    end
    in_valid <= 1'b0;

    // let the pipeline empty, then a margin for stray beats
    while (duty_book.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb_svpwm_duty_generator: done, clean");
    end else begin
      $display("tb_svpwm_duty_generator: done, errors");
    end
    $finish;
  end

endmodule
